>>> design/delivery_ack_timeout_tracker_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef DELIVERY_ACK_TIMEOUT_TRACKER_MACROS_SVH
`define DELIVERY_ACK_TIMEOUT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define DATT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DATT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DATT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DATT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/datt_pkg.sv
`timescale 1ns / 1ps
package datt_pkg;
  localparam int unsigned WindowDepthDef = 16;
  localparam int unsigned AckDepthDef = 16;
  localparam int unsigned MaxResults = 16;
  localparam logic [31:0] TimeoutReset = 32'd100;

  typedef enum logic [2:0] {
    ACT_SEND = 3'd0,
    ACT_RECV = 3'd1,
    ACT_ACK = 3'd2,
    ACT_TICK = 3'd3,
    ACT_FLUSH = 3'd4,
    ACT_CLEAR = 3'd5,
    ACT_NOP6 = 3'd6,
    ACT_NOP7 = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    KIND_ASSIGN = 3'd0,
    KIND_VERDICT = 3'd1,
    KIND_SUCCESS = 3'd2,
    KIND_FAILURE = 3'd3,
    KIND_ACK_OUT = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_RECV,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_ACK_SHIFT,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_SHIFT,
    ST_FL_RD,
    ST_FL_EMIT,
    ST_FL_SHIFT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic do_send;
    logic do_recv;
    logic do_clear;
    logic time_inc;
    logic pend_rd;
    logic pend_idx_inc;
    logic pend_idx_clr;
    logic pend_shift;
    logic pend_dec;
    logic ack_rd;
    logic ack_idx_inc;
    logic ack_idx_clr;
    logic ack_shift;
    logic ack_finish;
    logic emit_success;
    logic emit_failure;
    logic emit_ack;
    logic cnt_inc;
    logic cnt_clr;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic pend_empty;
    logic pend_idx_end;
    logic pend_shift_end;
    logic match;
    logic expired;
    logic ack_idx_end;
    logic ack_shift_end;
    logic cap_hit;
  } stat_t;
endpackage

>>> design/datt_ctrl.sv
`timescale 1ns / 1ps
`include "delivery_ack_timeout_tracker_macros.svh"
module datt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_start,
  input  datt_pkg::stat_t st,
  output datt_pkg::cmd_t  cmd,
  output logic            busy
);
  import datt_pkg::*;

  state_t state_r, state_nxt;
  logic act_valid;
  logic [2:0] emits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_start) begin
          unique case (st.act)
            ACT_SEND: state_nxt = ST_SEND;
            ACT_RECV: state_nxt = ST_RECV;
            ACT_ACK: state_nxt = ST_ACK_RD;
            ACT_TICK: state_nxt = ST_TICK_RD;
            ACT_FLUSH: state_nxt = ST_FL_RD;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEND, ST_RECV, ST_CLEAR: state_nxt = ST_IDLE;
      ST_ACK_RD: state_nxt = st.pend_idx_end ? ST_IDLE : ST_ACK_CMP;
      ST_ACK_CMP: state_nxt = st.match ? ST_ACK_SHIFT : ST_ACK_RD;
      ST_ACK_SHIFT: state_nxt = st.pend_shift_end ? ST_IDLE : ST_ACK_SHIFT;
      ST_TICK_RD: state_nxt = (st.pend_empty || st.cap_hit) ? ST_IDLE : ST_TICK_CMP;
      ST_TICK_CMP: state_nxt = st.expired ? ST_TICK_SHIFT : ST_IDLE;
      ST_TICK_SHIFT: state_nxt = st.pend_shift_end ? ST_TICK_RD : ST_TICK_SHIFT;
      ST_FL_RD: state_nxt = (st.ack_idx_end || st.cap_hit) ? ST_FL_SHIFT : ST_FL_EMIT;
      ST_FL_EMIT: state_nxt = ST_FL_RD;
      ST_FL_SHIFT: state_nxt = st.ack_shift_end ? ST_IDLE : ST_FL_SHIFT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_start;
        cmd.time_inc = in_start && (st.act == ACT_TICK);
        cmd.pend_idx_clr = 1'b1;
        cmd.ack_idx_clr = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_SEND: cmd.do_send = 1'b1;
      ST_RECV: cmd.do_recv = 1'b1;
      ST_CLEAR: cmd.do_clear = 1'b1;
      ST_ACK_RD: cmd.pend_rd = 1'b1;
      ST_ACK_CMP: begin
        cmd.pend_idx_inc = !st.match;
        cmd.emit_success = st.match;
      end
      ST_ACK_SHIFT: begin
        cmd.pend_shift = 1'b1;
        cmd.pend_dec = st.pend_shift_end;
      end
      ST_TICK_RD: cmd.pend_rd = 1'b1;
      ST_TICK_CMP: begin
        cmd.emit_failure = st.expired;
        cmd.cnt_inc = st.expired;
      end
      ST_TICK_SHIFT: begin
        cmd.pend_shift = 1'b1;
        cmd.pend_dec = st.pend_shift_end;
        cmd.pend_idx_clr = st.pend_shift_end;
      end
      ST_FL_RD: begin
        cmd.ack_rd = 1'b1;
        cmd.ack_idx_clr = st.ack_idx_end || st.cap_hit;
      end
      ST_FL_EMIT: begin
        cmd.emit_ack = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.ack_idx_inc = 1'b1;
      end
      ST_FL_SHIFT: begin
        cmd.ack_shift = 1'b1;
        cmd.ack_finish = st.ack_shift_end;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign act_valid = in_start && (st.act != ACT_NOP6) && (st.act != ACT_NOP7);
  assign emits = {cmd.emit_success, cmd.emit_failure, cmd.emit_ack};

  `DATT_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, (state_r == ST_IDLE) && act_valid, busy)
  `DATT_ASSERT_IMP(a_one_emit, clk, rst_n, 1'b1, $onehot0(emits))
  `DATT_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_r == ST_IDLE)
endmodule

>>> design/datt_dp.sv
`timescale 1ns / 1ps
`include "delivery_ack_timeout_tracker_macros.svh"
module datt_dp #(
  parameter int unsigned WINDOW_DEPTH = datt_pkg::WindowDepthDef,
  parameter int unsigned ACK_DEPTH = datt_pkg::AckDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      in_action,
  input  logic [31:0]     in_sequence_number,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  datt_pkg::cmd_t  cmd,
  output datt_pkg::stat_t st,
  output logic            out_valid,
  output logic [2:0]      out_result_kind,
  output logic [31:0]     out_sequence_out,
  output logic            out_accepted,
  output logic            out_overflow,
  output logic            out_last
);
  import datt_pkg::*;

  localparam int unsigned PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned PC = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AW = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
  localparam int unsigned AC = $clog2(ACK_DEPTH + 1);
  localparam int unsigned RC = $clog2(MaxResults + 1);

  logic [31:0] timeout_r, next_out_r, next_exp_r, time_r;
  logic [31:0] pseq_mem [WINDOW_DEPTH];
  logic [31:0] ptime_mem [WINDOW_DEPTH];
  logic [31:0] ack_mem [ACK_DEPTH];
  logic [PC-1:0] pend_cnt_r, pidx_r;
  logic [AC-1:0] ack_cnt_r, aidx_r, emit_n_r;
  logic [RC-1:0] res_cnt_r;
  logic [31:0] seq_r;
  logic [31:0] rd_seq_r, rd_time_r, rd_ack_r;
  logic [31:0] sh_seq_r, sh_time_r, sh_ack_r;
  logic [PC-1:0] pidx_p1;
  logic [AC-1:0] aidx_src;
  logic [31:0] age;
  logic [PW-1:0] pwr_idx;
  logic [AW-1:0] awr_idx;
  logic pwr_en, awr_en;
  logic [31:0] pwr_seq, pwr_time, awr_data;
  logic recv_new, send_ok, recv_ok;
  logic ov_r, vld_r, acc_r, last_r;
  logic [2:0] kind_r;
  logic [31:0] oseq_r;

  assign pidx_p1 = pidx_r + 1'b1;
  assign aidx_src = aidx_r + emit_n_r;
  assign age = time_r - rd_time_r;
  assign recv_new = (seq_r >= next_exp_r);
  assign send_ok = (pend_cnt_r < PC'(WINDOW_DEPTH));
  assign recv_ok = (ack_cnt_r < AC'(ACK_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
      next_out_r <= '0;
      next_exp_r <= '0;
      time_r <= '0;
      pend_cnt_r <= '0;
      ack_cnt_r <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (cmd.time_inc) time_r <= time_r + 32'd1;
      if (cmd.do_send) begin
        next_out_r <= next_out_r + 32'd1;
        if (send_ok) pend_cnt_r <= pend_cnt_r + 1'b1;
      end
      if (cmd.do_recv && recv_new) begin
        next_exp_r <= seq_r + 32'd1;
        if (recv_ok) ack_cnt_r <= ack_cnt_r + 1'b1;
      end
      if (cmd.pend_dec) pend_cnt_r <= pend_cnt_r - 1'b1;
      if (cmd.ack_finish) ack_cnt_r <= ack_cnt_r - emit_n_r;
      if (cmd.do_clear) begin
        next_out_r <= '0;
        next_exp_r <= '0;
        pend_cnt_r <= '0;
        ack_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= in_sequence_number;
    end
    if (cmd.pend_idx_clr) pidx_r <= '0;
    else if (cmd.pend_idx_inc || cmd.pend_shift) pidx_r <= pidx_p1;
    if (cmd.ack_idx_clr) aidx_r <= '0;
    else if (cmd.ack_idx_inc || cmd.ack_shift) aidx_r <= aidx_r + 1'b1;
    if (cmd.cnt_clr) res_cnt_r <= '0;
    else if (cmd.cnt_inc) res_cnt_r <= res_cnt_r + 1'b1;
    if (cmd.cnt_clr) emit_n_r <= '0;
    else if (cmd.emit_ack) emit_n_r <= emit_n_r + 1'b1;
  end

  always_comb begin
    pwr_en = 1'b0;
    pwr_idx = '0;
    pwr_seq = next_out_r;
    pwr_time = time_r;
    if (cmd.do_send && send_ok) begin
      pwr_en = 1'b1;
      pwr_idx = pend_cnt_r[PW-1:0];
    end else if (cmd.pend_shift && !st.pend_shift_end) begin
      pwr_en = 1'b1;
      pwr_idx = pidx_r[PW-1:0];
      pwr_seq = sh_seq_r;
      pwr_time = sh_time_r;
    end
    awr_en = 1'b0;
    awr_idx = '0;
    awr_data = seq_r;
    if (cmd.do_recv && recv_new && recv_ok) begin
      awr_en = 1'b1;
      awr_idx = ack_cnt_r[AW-1:0];
    end else if (cmd.ack_shift && !st.ack_shift_end) begin
      awr_en = 1'b1;
      awr_idx = aidx_r[AW-1:0];
      awr_data = sh_ack_r;
    end
  end

  // Shift reads prefetch the entry the next shift write copies.
  always_ff @(posedge clk) begin
    if (pwr_en) begin
      pseq_mem[pwr_idx] <= pwr_seq;
      ptime_mem[pwr_idx] <= pwr_time;
    end
    if (cmd.pend_rd) begin
      rd_seq_r <= pseq_mem[pidx_r[PW-1:0]];
      rd_time_r <= ptime_mem[pidx_r[PW-1:0]];
    end
    if (cmd.pend_rd || cmd.emit_success || cmd.emit_failure || cmd.pend_shift) begin
      sh_seq_r <= pseq_mem[PW'(cmd.pend_shift ? pidx_p1 + 1'b1 : pidx_p1)];
      sh_time_r <= ptime_mem[PW'(cmd.pend_shift ? pidx_p1 + 1'b1 : pidx_p1)];
    end
    if (awr_en) ack_mem[awr_idx] <= awr_data;
    if (cmd.ack_rd) rd_ack_r <= ack_mem[aidx_r[AW-1:0]];
    if (cmd.ack_rd || cmd.ack_shift) begin
      sh_ack_r <= ack_mem[AW'(cmd.ack_shift ? aidx_src + 1'b1 : emit_n_r)];
    end
  end

  always_comb begin
    st.act = action_t'(in_action);
    st.pend_empty = (pend_cnt_r == '0);
    st.pend_idx_end = (pidx_r >= pend_cnt_r);
    st.pend_shift_end = (pidx_p1 >= pend_cnt_r);
    st.match = (rd_seq_r == seq_r);
    st.expired = (age >= timeout_r);
    st.ack_idx_end = (aidx_r >= ack_cnt_r);
    st.ack_shift_end = (aidx_src >= ack_cnt_r);
    st.cap_hit = (res_cnt_r >= RC'(MaxResults));
  end

  logic tick_more;
  assign tick_more = (pend_cnt_r > PC'(1)) && (res_cnt_r + 1'b1 < RC'(MaxResults));
  logic [31:0] nxt_time;
  assign nxt_time = sh_time_r;
  logic flush_more;
  assign flush_more = (aidx_r + 1'b1 < ack_cnt_r) && (res_cnt_r + 1'b1 < RC'(MaxResults));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cmd.do_send || cmd.do_recv || cmd.emit_success || cmd.emit_failure
               || cmd.emit_ack;
    end
    if (cmd.do_send) begin
      kind_r <= KIND_ASSIGN;
      oseq_r <= next_out_r;
      acc_r <= send_ok;
      ov_r <= !send_ok;
      last_r <= 1'b1;
    end else if (cmd.do_recv) begin
      kind_r <= KIND_VERDICT;
      oseq_r <= seq_r;
      acc_r <= recv_new;
      ov_r <= recv_new && !recv_ok;
      last_r <= 1'b1;
    end else if (cmd.emit_success) begin
      kind_r <= KIND_SUCCESS;
      oseq_r <= seq_r;
      acc_r <= 1'b0;
      ov_r <= 1'b0;
      last_r <= 1'b1;
    end else if (cmd.emit_failure) begin
      kind_r <= KIND_FAILURE;
      oseq_r <= rd_seq_r;
      acc_r <= 1'b0;
      ov_r <= 1'b0;
      last_r <= !(tick_more && ((time_r - nxt_time) >= timeout_r));
    end else if (cmd.emit_ack) begin
      kind_r <= KIND_ACK_OUT;
      oseq_r <= rd_ack_r;
      acc_r <= 1'b0;
      ov_r <= 1'b0;
      last_r <= !flush_more;
    end
  end

  assign out_valid = vld_r;
  assign out_result_kind = kind_r;
  assign out_sequence_out = oseq_r;
  assign out_accepted = acc_r;
  assign out_overflow = ov_r;
  assign out_last = last_r;

  `DATT_ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, pend_cnt_r <= PC'(WINDOW_DEPTH))
  `DATT_ASSERT_IMP(a_ack_bound, clk, rst_n, 1'b1, ack_cnt_r <= AC'(ACK_DEPTH))
  `DATT_ASSERT_IMP(a_cap, clk, rst_n, 1'b1, res_cnt_r <= RC'(MaxResults))
endmodule

>>> design/delivery_ack_timeout_tracker.sv
`timescale 1ns / 1ps
// Tracks sends, receives, acks, ticks, flushes and clears, one request at a
// time. A request is taken when start is high and busy is low; results
// appear on out_valid and cannot be stalled, the final one marked by
// out_last. Send, receive and clear go from idle to their own action state
// and back. An ack walks the pending list, reading and then comparing each
// entry, and then shifts the entries above the match down one a cycle. A
// tick reads and compares the oldest pending entry and, for each expired
// one, reports a failure and shifts the pending entries above it down; a
// flush reads and emits each queued ack in turn and then compacts the queue.
module delivery_ack_timeout_tracker #(
  parameter int unsigned WINDOW_DEPTH = datt_pkg::WindowDepthDef,
  parameter int unsigned ACK_DEPTH = datt_pkg::AckDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_sequence_number,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_result_kind,
  output logic [31:0] out_sequence_out,
  output logic        out_accepted,
  output logic        out_overflow,
  output logic        out_last
);
  import datt_pkg::*;

  cmd_t cmd;
  stat_t st;

  datt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  datt_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .ACK_DEPTH(ACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_action(in_action),
    .in_sequence_number(in_sequence_number), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .st(st), .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_sequence_out(out_sequence_out), .out_accepted(out_accepted),
    .out_overflow(out_overflow), .out_last(out_last)
  );
endmodule
